FILE: rtl/ucsp_pkg.sv
// Package for the unicycle state propagation core: formats, register codes,
// CORDIC constants and the fixed-point helper functions.
// No dependencies.
package ucsp_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_ENTRIES  = 24;
   localparam int CORDIC_N      = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_TIME_STEP  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_GAIN = 8'd1;

   localparam logic [15:0] TIME_STEP_RST  = 16'd6554;
   localparam logic [15:0] SPEED_GAIN_RST = 16'd6237;

   localparam logic signed [20:0] TWO_PI_Q17  = 21'sd823550;
   localparam logic signed [20:0] PI_Q17      = 21'sd411775;
   localparam logic signed [20:0] HALF_PI_Q17 = 21'sd205887;
   // floor(A / 2pi) is taken as (A * RECIP_2PI) >>> RECIP_SHIFT, then corrected.
   localparam logic signed [21:0] RECIP_2PI   = 22'sd1335088;
   localparam int                 RECIP_SHIFT = 40;
   localparam logic signed [32:0] CORDIC_GAIN = 33'sh026DD3B6A;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [23:0] heading;
      logic signed [19:0] speed;
   } pose_type;

   function automatic logic signed [32:0] atan_q30(input int idx);
      logic signed [32:0] a;
      unique case (idx)
         0:  a = 33'sh03243F6A8;  1:  a = 33'sh01DAC6705;  2:  a = 33'sh00FADBAFC;
         3:  a = 33'sh007F56EA6;  4:  a = 33'sh003FEAB76;  5:  a = 33'sh001FFD55B;
         6:  a = 33'sh000FFFAAA;  7:  a = 33'sh0007FFF55;  8:  a = 33'sh0003FFFEA;
         9:  a = 33'sh0001FFFFD;  10: a = 33'sh0000FFFFF;  11: a = 33'sh00007FFFF;
         12: a = 33'sh00003FFFF;  13: a = 33'sh00001FFFF;  14: a = 33'sh00000FFFF;
         15: a = 33'sh000007FFF;  16: a = 33'sh000003FFF;  17: a = 33'sh000001FFF;
         18: a = 33'sh000000FFF;  19: a = 33'sh0000007FF;  20: a = 33'sh0000003FF;
         21: a = 33'sh0000001FF;  22: a = 33'sh0000000FF;  23: a = 33'sh00000007F;
         default: a = '0;
      endcase
      return a;
   endfunction

   function automatic logic signed [19:0] sat20(input logic signed [23:0] v);
      logic signed [19:0] r;
      if (v > 24'sd524287) r = 20'sh7FFFF;
      else if (v < -24'sd524288) r = 20'sh80000;
      else r = v[19:0];
      return r;
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
      logic signed [23:0] r;
      if (v > 25'sd8388607) r = 24'sh7FFFFF;
      else if (v < -25'sd8388608) r = 24'sh800000;
      else r = v[23:0];
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v[32] != v[31]) r = v[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
      else r = v[31:0];
      return r;
   endfunction

endpackage

FILE: rtl/ucsp_req_if.sv
// Input channel of the propagation core: pose and motion primitive.
// Depends on nothing.
interface ucsp_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [23:0] heading;
   logic signed [19:0] speed;
   logic signed [19:0] speed_command;
   logic signed [19:0] turn_rate;
   modport source (output valid, pos_x, pos_y, heading, speed, speed_command, turn_rate,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, heading, speed, speed_command, turn_rate,
                   output ready);
endinterface

FILE: rtl/ucsp_rsp_if.sv
// Result channel of the propagation core: next pose.
// Depends on nothing.
interface ucsp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] next_x;
   logic signed [31:0] next_y;
   logic signed [23:0] next_heading;
   logic signed [19:0] next_speed;
   modport source (output valid, next_x, next_y, next_heading, next_speed, input ready);
   modport sink   (input valid, next_x, next_y, next_heading, next_speed, output ready);
endinterface

FILE: rtl/ucsp_csr_if.sv
// Register write channel of the propagation core.
// Depends on ucsp_pkg for the index and data widths.
interface ucsp_csr_if;
   logic                               valid;
   logic                               ready;
   logic [ucsp_pkg::CSR_IDX_W-1:0]     index;
   logic [ucsp_pkg::CSR_DATA_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/unicycle_state_propagation_core.sv
// Unicycle pose propagator: lag, heading step, angle reduction, CORDIC, position step.
// Depends on ucsp_pkg and the ucsp_req_if, ucsp_rsp_if and ucsp_csr_if interfaces.
//
//   channel | dir | beat
//   req     | in  | pos_x, pos_y, heading, speed, speed_command, turn_rate
//   rsp     | out | next_x, next_y, next_heading, next_speed
//   csr     | in  | index, data (time_step = 0, speed_gain = 1)
//
// One beat enters per cycle unless the pipeline is frozen; there is one register per
// CORDIC micro-rotation, five ahead of it and three after it.
// When rsp holds an untaken result the whole pipeline freezes; otherwise req is ready.
// Synchronous reset clears the valid bits and loads the register defaults.
// csr is always ready.
module unicycle_state_propagation_core (
   input  logic        clock,
   input  logic        reset,
   ucsp_req_if.sink    req,
   ucsp_rsp_if.source  rsp,
   ucsp_csr_if.sink    csr
);
   import ucsp_pkg::*;

   localparam int NV = 5 + CORDIC_N + 3;

   logic [15:0] time_step_ff, speed_gain_ff;
   logic        adv;
   logic [NV-1:0] vld_ff;

   // Stage 1: products for lag and heading step.
   pose_type           p1_ff;
   logic signed [37:0] pv1_ff;
   logic signed [36:0] pt1_ff;
   logic signed [20:0] dv_in;
   // Stage 2: saturated speed/heading and midpoint sums.
   pose_type           p2_ff;
   logic signed [20:0] s2_ff;
   logic signed [24:0] a2_ff;
   logic signed [22:0] vr_in;
   logic signed [21:0] tr_in;
   logic signed [19:0] vn_in;
   logic signed [23:0] thn_in;
   // Stage 3: reciprocal product.
   pose_type           p3_ff;
   logic signed [20:0] s3_ff;
   logic signed [24:0] a3_ff;
   logic signed [46:0] q3_ff;
   // Stage 4: raw remainder.
   pose_type           p4_ff;
   logic signed [20:0] s4_ff;
   logic signed [27:0] r4_ff;
   logic signed [6:0]  q_in;
   // Stage 5 feeds CORDIC slot 0.
   logic signed [27:0] r1_in, r2_in, r3_in;
   logic               neg_in;
   pose_type           pc_ff [CORDIC_N+1];
   logic signed [20:0] sc_ff [CORDIC_N+1];
   logic               ngc_ff [CORDIC_N+1];
   logic signed [32:0] cx_ff [CORDIC_N+1];
   logic signed [32:0] cy_ff [CORDIC_N+1];
   logic signed [32:0] cz_ff [CORDIC_N+1];
   // Post stages.
   pose_type           pa_ff, pb_ff;
   logic signed [53:0] mc_ff, ms_ff;
   logic signed [39:0] tc_ff, ts_ff;
   logic signed [32:0] cos_in, sin_in;
   logic signed [23:0] rc_in, rs_in;
   logic signed [22:0] dx_in, dy_in;
   logic signed [31:0] nx_ff, ny_ff;
   logic signed [23:0] nh_ff;
   logic signed [19:0] ns_ff;

   assign adv       = !vld_ff[NV-1] || rsp.ready;
   assign req.ready = adv;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff  <= TIME_STEP_RST;
         speed_gain_ff <= SPEED_GAIN_RST;
      end else if (csr.valid) begin
         if (csr.index == REG_TIME_STEP) time_step_ff <= csr.data[15:0];
         else if (csr.index == REG_SPEED_GAIN) speed_gain_ff <= csr.data[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NV-2:0], req.valid};
      end
   end

   always_comb begin
      dv_in  = 21'(req.speed_command) - 21'(req.speed);
      vr_in  = 23'((39'(pv1_ff) + 39'sd32768) >>> 16);
      tr_in  = 22'((38'(pt1_ff) + 38'sd32768) >>> 16);
      vn_in  = sat20(24'(p1_ff.speed) + 24'(vr_in));
      thn_in = sat24(25'(p1_ff.heading) + 25'(tr_in));
      q_in   = q3_ff[46:40];
      // Remainder into [0, 2pi), then [-pi, pi), then fold into [-pi/2, pi/2].
      if (r4_ff < 0) r1_in = r4_ff + 28'(TWO_PI_Q17);
      else if (r4_ff >= 28'(TWO_PI_Q17)) r1_in = r4_ff - 28'(TWO_PI_Q17);
      else r1_in = r4_ff;
      r2_in = (r1_in >= 28'(PI_Q17)) ? r1_in - 28'(TWO_PI_Q17) : r1_in;
      neg_in = 1'b0;
      r3_in  = r2_in;
      if (r2_in > 28'(HALF_PI_Q17)) begin
         r3_in  = r2_in - 28'(PI_Q17);
         neg_in = 1'b1;
      end else if (r2_in < -28'(HALF_PI_Q17)) begin
         r3_in  = r2_in + 28'(PI_Q17);
         neg_in = 1'b1;
      end
      cos_in = ngc_ff[CORDIC_N] ? -cx_ff[CORDIC_N] : cx_ff[CORDIC_N];
      sin_in = ngc_ff[CORDIC_N] ? -cy_ff[CORDIC_N] : cy_ff[CORDIC_N];
      rc_in  = 24'((55'(mc_ff) + 55'sd536870912) >>> 30);
      rs_in  = 24'((55'(ms_ff) + 55'sd536870912) >>> 30);
      dx_in  = 23'((41'(tc_ff) + 41'sd65536) >>> 17);
      dy_in  = 23'((41'(ts_ff) + 41'sd65536) >>> 17);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff.x       <= req.pos_x;
         p1_ff.y       <= req.pos_y;
         p1_ff.heading <= req.heading;
         p1_ff.speed   <= req.speed;
         pv1_ff <= 38'(dv_in) * 38'($signed({1'b0, speed_gain_ff}));
         pt1_ff <= 37'(req.turn_rate) * 37'($signed({1'b0, time_step_ff}));

         p2_ff.x       <= p1_ff.x;
         p2_ff.y       <= p1_ff.y;
         p2_ff.heading <= thn_in;
         p2_ff.speed   <= vn_in;
         s2_ff <= 21'(p1_ff.speed) + 21'(vn_in);
         a2_ff <= 25'(p1_ff.heading) + 25'(thn_in);

         p3_ff <= p2_ff;
         s3_ff <= s2_ff;
         a3_ff <= a2_ff;
         q3_ff <= 47'(a2_ff) * 47'(RECIP_2PI);

         p4_ff <= p3_ff;
         s4_ff <= s3_ff;
         r4_ff <= 28'(a3_ff) - 28'(q_in) * 28'(TWO_PI_Q17);

         pc_ff[0]  <= p4_ff;
         sc_ff[0]  <= s4_ff;
         ngc_ff[0] <= neg_in;
         cx_ff[0]  <= CORDIC_GAIN;
         cy_ff[0]  <= '0;
         cz_ff[0]  <= 33'(r3_in) <<< 13;

         pa_ff <= pc_ff[CORDIC_N];
         mc_ff <= 54'(sc_ff[CORDIC_N]) * 54'(cos_in);
         ms_ff <= 54'(sc_ff[CORDIC_N]) * 54'(sin_in);

         pb_ff <= pa_ff;
         tc_ff <= 40'(rc_in) * 40'($signed({1'b0, time_step_ff}));
         ts_ff <= 40'(rs_in) * 40'($signed({1'b0, time_step_ff}));

         nx_ff <= sat32(33'(pb_ff.x) + 33'(dx_in));
         ny_ff <= sat32(33'(pb_ff.y) + 33'(dy_in));
         nh_ff <= pb_ff.heading;
         ns_ff <= pb_ff.speed;
      end
   end

   // One micro-rotation per register stage.
   for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
      logic signed [32:0] xs, ys;
      assign xs = cx_ff[i] >>> i;
      assign ys = cy_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (adv) begin
            pc_ff[i+1]  <= pc_ff[i];
            sc_ff[i+1]  <= sc_ff[i];
            ngc_ff[i+1] <= ngc_ff[i];
            if (!cz_ff[i][32]) begin
               cx_ff[i+1] <= cx_ff[i] - ys;
               cy_ff[i+1] <= cy_ff[i] + xs;
               cz_ff[i+1] <= cz_ff[i] - atan_q30(i);
            end else begin
               cx_ff[i+1] <= cx_ff[i] + ys;
               cy_ff[i+1] <= cy_ff[i] - xs;
               cz_ff[i+1] <= cz_ff[i] + atan_q30(i);
            end
         end
      end
   end

   assign rsp.valid        = vld_ff[NV-1];
   assign rsp.next_x       = nx_ff;
   assign rsp.next_y       = ny_ff;
   assign rsp.next_heading = nh_ff;
   assign rsp.next_speed   = ns_ff;

endmodule

FILE: test/tb_top.sv
// Self-checking bench for unicycle_state_propagation_core: directed and random poses
// over several time step and speed gain settings, checked against a fixed-point predictor.
// Depends on ucsp_pkg and the ucsp_req_if, ucsp_rsp_if and ucsp_csr_if interfaces.
`timescale 1ns / 1ps

module tb_top;
   import ucsp_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_PER_SETTING = 333;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 8'd7;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [23:0] heading;
      logic signed [19:0] speed;
      logic signed [19:0] speed_command;
      logic signed [19:0] turn_rate;
   } motion_beat_type;

   class pose_scoreboard_type;
      longint dt;
      longint alpha;
      pose_type next_poses[$];
      int mismatches;

      function new();
         dt = longint'(TIME_STEP_RST);
         alpha = longint'(SPEED_GAIN_RST);
         mismatches = 0;
      endfunction

      static function longint round_shift(longint v, int s);
         return (v + (longint'(1) <<< (s - 1))) >>> s;
      endfunction

      static function longint clamp(longint v, int w);
         longint hi, lo;
         hi = (longint'(1) <<< (w - 1)) - 1;
         lo = -hi - 1;
         return (v > hi) ? hi : ((v < lo) ? lo : v);
      endfunction

      // Rotation-mode CORDIC on an angle sum in Q.17, giving cos and sin in Q.30.
      static function void rotate(longint ang, output longint c, output longint s);
         longint arctan[24] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
         longint r, x, y, z, xs, ys;
         bit flip;
         r = ang % longint'(TWO_PI_Q17);
         flip = 0;
         if (r < 0) r += longint'(TWO_PI_Q17);
         if (r >= longint'(PI_Q17)) r -= longint'(TWO_PI_Q17);
         if (r > longint'(HALF_PI_Q17)) begin
            r -= longint'(PI_Q17);
            flip = 1;
         end else if (r < -longint'(HALF_PI_Q17)) begin
            r += longint'(PI_Q17);
            flip = 1;
         end
         x = longint'(CORDIC_GAIN);
         y = 0;
         z = r * 8192;
         for (int i = 0; i < CORDIC_N; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x -= ys; y += xs; z -= arctan[i];
            end else begin
               x += ys; y -= xs; z += arctan[i];
            end
         end
         c = flip ? -x : x;
         s = flip ? -y : y;
      endfunction

      function void note_motion(motion_beat_type b);
         longint v, th, vn, thn, ssum, c, s, dx, dy;
         pose_type p;
         v = longint'(b.speed);
         th = longint'(b.heading);
         vn = clamp(v + round_shift((longint'(b.speed_command) - v) * alpha, 16), 20);
         thn = clamp(th + round_shift(longint'(b.turn_rate) * dt, 16), 24);
         ssum = v + vn;
         rotate(th + thn, c, s);
         dx = round_shift(round_shift(ssum * c, 30) * dt, 17);
         dy = round_shift(round_shift(ssum * s, 30) * dt, 17);
         p.x = 32'(clamp(longint'(b.x) + dx, 32));
         p.y = 32'(clamp(longint'(b.y) + dy, 32));
         p.heading = 24'(thn);
         p.speed = 20'(vn);
         next_poses = {next_poses, p};
      endfunction

      function void check_pose(pose_type got);
         pose_type want;
         if (next_poses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat: %p", got);
            return;
         end
         want = next_poses.pop_front();
         if (got.x !== want.x || got.y !== want.y || got.heading !== want.heading ||
             got.speed !== want.speed) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"pose mismatch: expected x=%0d y=%0d hd=%0d v=%0d, ",
                         "got x=%0d y=%0d hd=%0d v=%0d"},
                        want.x, want.y, want.heading, want.speed,
                        got.x, got.y, got.heading, got.speed);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int cycles;
   bit calm;
   pose_scoreboard_type board;

   ucsp_req_if req();
   ucsp_rsp_if rsp();
   ucsp_csr_if csr();

   unicycle_state_propagation_core dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Result side: check at the falling edge, where the beat is stable, then pick the next ready.
   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (!reset && rsp.valid && rsp.ready)
            board.check_pose('{rsp.next_x, rsp.next_y, rsp.next_heading, rsp.next_speed});
         @(posedge clock);
         rsp.ready <= calm || ($urandom_range(0, 99) >= 19);
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      bit taken;
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= value;
      do begin
         @(negedge clock);
         taken = csr.ready;
         @(posedge clock);
      end while (!taken);
      if (idx == REG_TIME_STEP) board.dt = longint'(value[15:0]);
      else if (idx == REG_SPEED_GAIN) board.alpha = longint'(value[15:0]);
   endtask

   task automatic send_motion(motion_beat_type b);
      bit taken;
      if (!calm && $urandom_range(0, 99) < 19) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.pos_x <= b.x;
      req.pos_y <= b.y;
      req.heading <= b.heading;
      req.speed <= b.speed;
      req.speed_command <= b.speed_command;
      req.turn_rate <= b.turn_rate;
      do begin
         @(negedge clock);
         taken = req.ready;
         @(posedge clock);
      end while (!taken);
      board.note_motion(b);
   endtask

   task automatic send_directed();
      send_motion(motion_beat_type'{'0, '0, '0, '0, '0, '0});
      send_motion(motion_beat_type'{32'sh7FFFFFF0, 32'sh7FFFFFF0, 24'sd51472,
                                    20'sh7FFFF, 20'sh7FFFF, '0});
      send_motion(motion_beat_type'{32'sh80000010, 32'sh80000010, -24'sd154416,
                                    20'sh7FFFF, 20'sh7FFFF, '0});
      send_motion(motion_beat_type'{'0, '0, 24'sh7FFFFF, 20'sh40000, 20'sh40000,
                                    20'sh7FFFF});
      send_motion(motion_beat_type'{'0, '0, 24'sh800000, -20'sh40000, '0, 20'sh80000});
      send_motion(motion_beat_type'{32'sd100, -32'sd100, '0, 20'sh80000, 20'sh80000, '0});
      send_motion(motion_beat_type'{-32'sd5, 32'sd5, '0, 20'sh80000, 20'sh7FFFF,
                                    20'sh12345});
      send_motion(motion_beat_type'{32'sd7, 32'sd7, '0, 20'sh7FFFF, 20'sh80000,
                                    -20'sh12345});
      send_motion(motion_beat_type'{'0, '0, 24'sd102943, 20'sh10000, 20'sh10000, '0});
      send_motion(motion_beat_type'{'0, '0, 24'sd102944, 20'sh10000, 20'sh10000, '0});
      send_motion(motion_beat_type'{'0, '0, -24'sd102944, 20'sh10000, 20'sh10000, '0});
      send_motion(motion_beat_type'{'0, '0, 24'sd205887, 20'sh10000, 20'sh10000, '0});
      send_motion(motion_beat_type'{'0, '0, 24'sd205888, 20'sh10000, 20'sh10000, '0});
      send_motion(motion_beat_type'{'0, '0, -24'sd205888, -20'sh10000, 20'sh10000, '0});
      send_motion(motion_beat_type'{32'sh7FFFFFFF, 32'sh80000000, 24'sd3000000,
                                    20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF});
      send_motion(motion_beat_type'{32'sh80000000, 32'sh7FFFFFFF, -24'sd3000000,
                                    20'sh80000, 20'sh80000, 20'sh80000});
      send_motion(motion_beat_type'{32'sh12345678, -32'sh1234567, 24'sd411775,
                                    20'sh08000, 20'sh30000, 20'sh01000});
   endtask

   function automatic motion_beat_type random_motion();
      motion_beat_type b;
      b.x = $urandom();
      b.y = $urandom();
      b.heading = 24'($urandom());
      b.speed = 20'($urandom());
      b.speed_command = 20'($urandom());
      b.turn_rate = 20'($urandom());
      // Most beats look like a planner's: moderate positions, speeds and turn rates.
      if ($urandom_range(0, 99) < 70) begin
         b.x = $signed(b.x) >>> 6;
         b.y = $signed(b.y) >>> 6;
         b.speed = $signed(b.speed) >>> 2;
         b.speed_command = $signed(b.speed_command) >>> 2;
         b.turn_rate = $signed(b.turn_rate) >>> 3;
      end
      return b;
   endfunction

   initial begin
      logic [15:0] steps[5];
      logic [15:0] gains[5];
      board = new();
      calm = 0;
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.pos_x <= '0;
      req.pos_y <= '0;
      req.heading <= '0;
      req.speed <= '0;
      req.speed_command <= '0;
      req.turn_rate <= '0;
      csr.valid <= 1'b0;
      csr.index <= '0;
      csr.data <= '0;
      steps = '{16'd6554, 16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(1, 65535))};
      gains = '{16'd6237, 16'd0, 16'hFFFF, 16'h8000, 16'($urandom())};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int p = 0; p < 5; p++) begin
         // The upper data bits must be dropped and the unmapped index ignored.
         write_reg(REG_TIME_STEP, {16'hA5C3, steps[p]});
         write_reg(REG_SPEED_GAIN, {16'h5A3C, gains[p]});
         write_reg(REG_UNMAPPED, $urandom());
         csr.valid <= 1'b0;
         @(posedge clock);
         send_directed();
         for (int i = 0; i < RANDOM_PER_SETTING; i++) begin
            calm = (p == 2) && (i >= 50) && (i < 250);
            send_motion(random_motion());
         end
         calm = 0;
         req.valid <= 1'b0;
         while (board.next_poses.size() != 0) @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);
      end
      if (board.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
